FILE: sv/pdsc_pkg.sv
// Shared types, constants and control codes of the PID steering core.
// No dependencies; used by every other file of the block.
package pdsc_pkg;

  localparam int unsigned ERR_W   = 5;
  localparam int unsigned GAIN_W  = 8;
  localparam int unsigned INT_W   = 15;
  localparam int unsigned LIM_W   = 14;
  localparam int unsigned ACC_W   = 17;
  localparam int unsigned CORR_W  = 14;
  localparam int unsigned DIFF_W  = 6;
  localparam int unsigned MAG_W   = 14;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam int unsigned CLAMP_FACTOR = 50;
  localparam int unsigned DIV_STEPS    = MAG_W;
  localparam int unsigned MUL_STEPS    = GAIN_W;
  localparam int unsigned CNT_W        = $clog2(DIV_STEPS);

  localparam logic [GAIN_W-1:0] DRIVE_MAX = 8'd255;
  localparam logic signed [ACC_W-1:0] CORR_MAX = 17'sd8191;
  localparam logic signed [ACC_W-1:0] CORR_MIN = -17'sd8192;

  localparam logic [GAIN_W-1:0] GAIN_P_RST     = 8'd8;
  localparam logic [GAIN_W-1:0] GAIN_I_RST     = 8'd20;
  localparam logic [GAIN_W-1:0] GAIN_D_RST     = 8'd10;
  localparam logic [GAIN_W-1:0] BASE_SPEED_RST = 8'd85;

  typedef enum logic [1:0] {
    REG_GAIN_P     = 2'd0,
    REG_GAIN_I     = 2'd1,
    REG_GAIN_D     = 2'd2,
    REG_BASE_SPEED = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
    logic [GAIN_W-1:0] base_speed;
    logic [LIM_W-1:0]  limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_INT,
    ST_CLAMP,
    ST_ABS,
    ST_DIV,
    ST_QSIGN,
    ST_MULP,
    ST_MULD,
    ST_LEFT,
    ST_RIGHT,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIFF,
    OP_INT,
    OP_CLAMP,
    OP_ABS,
    OP_DIV,
    OP_QSIGN,
    OP_MULP,
    OP_MULD,
    OP_LEFT,
    OP_RIGHT,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic last;
  } ctrl_t;

endpackage

FILE: sv/pid_differential_steering_core.sv
// PID steering core: one request at a time. A result is valid once the sequencer
// leaves its done state; the block is idle again in that same cycle, or stays
// in its done state while a previous result is still held by out_stall.
// Most of the sequence is the 14-step restoring divide and the two 8-step
// shift-add multiplies, all run through the one shared adder.
// Synchronous reset clears gains to defaults, integral and previous error to zero.
module pid_differential_steering_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pdsc_pkg::ADDR_W-1:0]          paddr,
  input  logic [pdsc_pkg::DATA_W-1:0]          pwdata,
  output logic [pdsc_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [pdsc_pkg::ERR_W-1:0]    steer_error,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [pdsc_pkg::GAIN_W-1:0]          left_drive,
  output logic [pdsc_pkg::GAIN_W-1:0]          right_drive,
  output logic signed [pdsc_pkg::CORR_W-1:0]   steer_correction
);
  import pdsc_pkg::*;

  cfg_t  cfg;
  ctrl_t ctrl;

  pdsc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pdsc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  pdsc_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .ctrl             (ctrl),
    .cfg              (cfg),
    .steer_error      (steer_error),
    .left_drive       (left_drive),
    .right_drive      (right_drive),
    .steer_correction (steer_correction)
  );

endmodule

FILE: sv/pdsc_regs.sv
// Configuration register file on an APB-style slave port.
// Depends on pdsc_pkg; feeds the gains, base speed and integral limit to the datapath.
module pdsc_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pdsc_pkg::ADDR_W-1:0]   paddr,
  input  logic [pdsc_pkg::DATA_W-1:0]   pwdata,
  output logic [pdsc_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output pdsc_pkg::cfg_t                cfg
);
  import pdsc_pkg::*;

  logic [GAIN_W-1:0] gain_p;
  logic [GAIN_W-1:0] gain_i;
  logic [GAIN_W-1:0] gain_d;
  logic [GAIN_W-1:0] base_speed;
  reg_idx_t          idx;
  logic              wr;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p     <= GAIN_P_RST;
      gain_i     <= GAIN_I_RST;
      gain_d     <= GAIN_D_RST;
      base_speed <= BASE_SPEED_RST;
    end else if (wr) begin
      case (idx)
        REG_GAIN_P:     gain_p     <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:     gain_i     <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:     gain_d     <= pwdata[GAIN_W-1:0];
        REG_BASE_SPEED: base_speed <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_P:     prdata = {{(DATA_W-GAIN_W){1'b0}}, gain_p};
      REG_GAIN_I:     prdata = {{(DATA_W-GAIN_W){1'b0}}, gain_i};
      REG_GAIN_D:     prdata = {{(DATA_W-GAIN_W){1'b0}}, gain_d};
      REG_BASE_SPEED: prdata = {{(DATA_W-GAIN_W){1'b0}}, base_speed};
      default:        prdata = '0;
    endcase
  end

  // limit = 50 * gain_i, constant multiply
  assign cfg.gain_p     = gain_p;
  assign cfg.gain_i     = gain_i;
  assign cfg.gain_d     = gain_d;
  assign cfg.base_speed = base_speed;
  assign cfg.limit      = LIM_W'({{(LIM_W-GAIN_W){1'b0}}, gain_i} * LIM_W'(CLAMP_FACTOR));

endmodule

FILE: sv/pdsc_seq.sv
// Sequencer: steps one request through the shared-adder datapath.
// Depends on pdsc_pkg; drives pdsc_dp through a ctrl_t word.
module pdsc_seq (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output pdsc_pkg::ctrl_t ctrl
);
  import pdsc_pkg::*;

  state_t            state;
  state_t            state_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              out_valid_next;
  logic              div_last;
  logic              mul_last;
  logic              can_load;

  assign div_last = (cnt == CNT_W'(DIV_STEPS - 1));
  assign mul_last = (cnt == CNT_W'(MUL_STEPS - 1));
  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_INT;
      ST_INT:   state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_ABS;
      ST_ABS:   state_next = ST_DIV;
      ST_DIV:   if (div_last) state_next = ST_QSIGN;
      ST_QSIGN: state_next = ST_MULP;
      ST_MULP:  if (mul_last) state_next = ST_MULD;
      ST_MULD:  if (mul_last) state_next = ST_LEFT;
      ST_LEFT:  state_next = ST_RIGHT;
      ST_RIGHT: state_next = ST_DONE;
      ST_DONE:  if (can_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_next = '0;
    if ((state == ST_DIV && !div_last) ||
        ((state == ST_MULP || state == ST_MULD) && !mul_last)) begin
      cnt_next = cnt + 1'b1;
    end
  end

  always_comb begin
    ctrl.op        = OP_NONE;
    ctrl.last      = mul_last;
    in_stall       = 1'b1;
    out_valid_next = out_valid && out_stall;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) ctrl.op = OP_LOAD;
      end
      ST_DIFF:  ctrl.op = OP_DIFF;
      ST_INT:   ctrl.op = OP_INT;
      ST_CLAMP: ctrl.op = OP_CLAMP;
      ST_ABS:   ctrl.op = OP_ABS;
      ST_DIV:   ctrl.op = OP_DIV;
      ST_QSIGN: ctrl.op = OP_QSIGN;
      ST_MULP:  ctrl.op = OP_MULP;
      ST_MULD:  ctrl.op = OP_MULD;
      ST_LEFT:  ctrl.op = OP_LEFT;
      ST_RIGHT: ctrl.op = OP_RIGHT;
      ST_DONE: begin
        if (can_load) begin
          ctrl.op        = OP_OUT;
          out_valid_next = 1'b1;
        end
      end
      default: ctrl.op = OP_NONE;
    endcase
  end

endmodule

FILE: sv/pdsc_dp.sv
// Datapath: controller state and one shared 17-bit add/subtract unit that
// serves the difference, integral, magnitude, restoring divide, shift-add multiplies and mixing.
// Depends on pdsc_pkg; controlled by pdsc_seq.
module pdsc_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  pdsc_pkg::ctrl_t                      ctrl,
  input  pdsc_pkg::cfg_t                       cfg,
  input  logic signed [pdsc_pkg::ERR_W-1:0]    steer_error,
  output logic [pdsc_pkg::GAIN_W-1:0]          left_drive,
  output logic [pdsc_pkg::GAIN_W-1:0]          right_drive,
  output logic signed [pdsc_pkg::CORR_W-1:0]   steer_correction
);
  import pdsc_pkg::*;

  logic [ERR_W-1:0]  err;
  logic [ERR_W-1:0]  prev;
  logic [DIFF_W-1:0] diff;
  logic [INT_W-1:0]  integ;
  logic [ACC_W-1:0]  acc;
  logic [GAIN_W-1:0] rem;
  logic [MAG_W-1:0]  dvd;
  logic [MAG_W-1:0]  quo;
  logic              neg;
  logic [ACC_W-1:0]  mcand;
  logic [GAIN_W-1:0] mgain;
  logic [GAIN_W-1:0] left_t;
  logic [GAIN_W-1:0] right_t;

  logic [ACC_W-1:0]  add_a;
  logic [ACC_W-1:0]  add_b;
  logic              add_sub;
  logic [ACC_W-1:0]  add_sum;

  logic [ACC_W-1:0]  lim;
  logic [ACC_W-1:0]  neg_lim;
  logic [ACC_W-1:0]  corr_sat;
  logic [GAIN_W-1:0] drive_sat;

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + ACC_W'(add_sub);

  assign lim     = {{(ACC_W-LIM_W){1'b0}}, cfg.limit};
  assign neg_lim = ~lim + 1'b1;

  always_comb begin
    if ($signed(acc) > CORR_MAX)      corr_sat = CORR_MAX;
    else if ($signed(acc) < CORR_MIN) corr_sat = CORR_MIN;
    else                              corr_sat = acc;
  end

  always_comb begin
    if (add_sum[ACC_W-1])               drive_sat = '0;
    else if (add_sum[ACC_W-2:GAIN_W] != '0) drive_sat = DRIVE_MAX;
    else                                drive_sat = add_sum[GAIN_W-1:0];
  end

  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    case (ctrl.op)
      OP_DIFF: begin
        add_a   = {{(ACC_W-ERR_W){err[ERR_W-1]}}, err};
        add_b   = {{(ACC_W-ERR_W){prev[ERR_W-1]}}, prev};
        add_sub = 1'b1;
      end
      OP_INT: begin
        add_a = {{(ACC_W-INT_W){integ[INT_W-1]}}, integ};
        add_b = {{(ACC_W-ERR_W){err[ERR_W-1]}}, err};
      end
      OP_ABS: begin
        add_b   = {{(ACC_W-INT_W){integ[INT_W-1]}}, integ};
        add_sub = integ[INT_W-1];
      end
      OP_DIV: begin
        add_a   = {{(ACC_W-GAIN_W-1){1'b0}}, rem, dvd[MAG_W-1]};
        add_b   = {{(ACC_W-GAIN_W){1'b0}}, cfg.gain_i};
        add_sub = 1'b1;
      end
      OP_QSIGN: begin
        add_b   = (cfg.gain_i == '0) ? '0 : {{(ACC_W-MAG_W){1'b0}}, quo};
        add_sub = neg;
      end
      OP_MULP, OP_MULD: begin
        add_a = acc;
        add_b = mgain[0] ? mcand : '0;
      end
      OP_LEFT: begin
        add_a = {{(ACC_W-GAIN_W){1'b0}}, cfg.base_speed};
        add_b = corr_sat;
      end
      OP_RIGHT: begin
        add_a   = {{(ACC_W-GAIN_W){1'b0}}, cfg.base_speed};
        add_b   = corr_sat;
        add_sub = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ <= '0;
      prev  <= '0;
    end else begin
      case (ctrl.op)
        OP_DIFF: prev <= err;
        OP_CLAMP: begin
          if ($signed(acc) > $signed(lim))          integ <= lim[INT_W-1:0];
          else if ($signed(acc) < $signed(neg_lim)) integ <= neg_lim[INT_W-1:0];
          else                                      integ <= acc[INT_W-1:0];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: err  <= steer_error;
      OP_DIFF: diff <= add_sum[DIFF_W-1:0];
      OP_INT:  acc  <= add_sum;
      OP_ABS: begin
        dvd <= add_sum[MAG_W-1:0];
        neg <= integ[INT_W-1];
        rem <= '0;
        quo <= '0;
      end
      OP_DIV: begin
        if (!add_sum[ACC_W-1]) rem <= add_sum[GAIN_W-1:0];
        else                   rem <= {rem[GAIN_W-2:0], dvd[MAG_W-1]};
        dvd <= {dvd[MAG_W-2:0], 1'b0};
        quo <= {quo[MAG_W-2:0], ~add_sum[ACC_W-1]};
      end
      OP_QSIGN: begin
        acc   <= add_sum;
        mcand <= {{(ACC_W-ERR_W){err[ERR_W-1]}}, err};
        mgain <= cfg.gain_p;
      end
      OP_MULP, OP_MULD: begin
        acc <= add_sum;
        if (ctrl.op == OP_MULP && ctrl.last) begin
          mcand <= {{(ACC_W-DIFF_W){diff[DIFF_W-1]}}, diff};
          mgain <= cfg.gain_d;
        end else begin
          mcand <= {mcand[ACC_W-2:0], 1'b0};
          mgain <= {1'b0, mgain[GAIN_W-1:1]};
        end
      end
      OP_LEFT:  left_t  <= drive_sat;
      OP_RIGHT: right_t <= drive_sat;
      OP_OUT: begin
        left_drive       <= left_t;
        right_drive      <= right_t;
        steer_correction <= corr_sat[CORR_W-1:0];
      end
      default: ;
    endcase
  end

endmodule

FILE: tb/sv/tb_pid_differential_steering_core.sv
// Self-checking testbench for pid_differential_steering_core: directed table, then random phases.
// Depends on pdsc_pkg and the core; expected drives come from a local model of the control law or the table.
module tb_pid_differential_steering_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pdsc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 90;

  typedef enum {ROW_WRITE, ROW_ITEM} row_kind_t;
  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [GAIN_W-1:0]        left;
    logic [GAIN_W-1:0]        right;
    logic signed [CORR_W-1:0] corr;
  } drive_t;

  typedef struct {
    row_kind_t         kind;
    reg_idx_t          idx;
    logic [GAIN_W-1:0] value;
    logic [ERR_W-1:0]  err;
    bit                known;
    drive_t            drv;
  } row_t;

  logic                      clk;
  logic                      rst         = 1'b1;
  logic                      psel        = 1'b0;
  logic                      penable     = 1'b0;
  logic                      pwrite      = 1'b0;
  logic [ADDR_W-1:0]         paddr       = '0;
  logic [DATA_W-1:0]         pwdata      = '0;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic signed [ERR_W-1:0]   steer_error = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic [GAIN_W-1:0]         left_drive;
  logic [GAIN_W-1:0]         right_drive;
  logic signed [CORR_W-1:0]  steer_correction;

  // model copy of the registers and the controller state
  logic [GAIN_W-1:0]         cfg_gain_p     = GAIN_P_RST;
  logic [GAIN_W-1:0]         cfg_gain_i     = GAIN_I_RST;
  logic [GAIN_W-1:0]         cfg_gain_d     = GAIN_D_RST;
  logic [GAIN_W-1:0]         cfg_base_speed = BASE_SPEED_RST;
  logic signed [INT_W-1:0]   integral_acc   = '0;
  logic signed [ERR_W-1:0]   last_err       = '0;

  drive_t                    expected_drives[$];
  row_t                      plan[$];
  int                        mismatch_count = 0;
  int                        results_seen   = 0;
  int                        quiet_cycles   = 0;
  int                        gap_pct        = 0;
  int                        stall_pct      = 0;

  pid_differential_steering_core dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .steer_error      (steer_error),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .left_drive       (left_drive),
    .right_drive      (right_drive),
    .steer_correction (steer_correction)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int sat(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // one control update: integral with clamp, PID sum, saturated differential mix
  function automatic drive_t steer_update(input logic signed [ERR_W-1:0] err);
    int     e;
    int     lim;
    int     acc;
    int     iq;
    int     corr;
    drive_t d;
    e    = err;
    lim  = CLAMP_FACTOR * int'(cfg_gain_i);
    acc  = sat(int'(integral_acc) + e, -lim, lim);
    iq   = (cfg_gain_i != '0) ? acc / int'(cfg_gain_i) : 0;
    corr = int'(cfg_gain_p) * e + iq + int'(cfg_gain_d) * (e - int'(last_err));
    integral_acc = acc[INT_W-1:0];
    last_err     = err;
    corr    = sat(corr, -8192, 8191);
    d.corr  = corr[CORR_W-1:0];
    d.left  = GAIN_W'(sat(int'(cfg_base_speed) + corr, 0, 255));
    d.right = GAIN_W'(sat(int'(cfg_base_speed) - corr, 0, 255));
    return d;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_setting(input int lo);
    case ($urandom_range(0, 5))
      0: return GAIN_W'(lo);
      1: return 8'd255;
      2, 3: return GAIN_W'($urandom_range(lo, 12));
      default: return GAIN_W'($urandom_range(lo, 255));
    endcase
  endfunction

  function automatic void plan_write(input reg_idx_t idx, input int value);
    row_t r;
    r.kind  = ROW_WRITE;
    r.idx   = idx;
    r.value = GAIN_W'(value);
    r.err   = '0;
    r.known = 1'b0;
    r.drv   = '0;
    plan.push_back(r);
  endfunction

  function automatic void plan_item(input int err);
    row_t r;
    r.kind  = ROW_ITEM;
    r.idx   = REG_GAIN_P;
    r.value = '0;
    r.err   = err[ERR_W-1:0];
    r.known = 1'b0;
    r.drv   = '0;
    plan.push_back(r);
  endfunction

  function automatic void plan_known(input int err, input int l, input int rr, input int c);
    row_t r;
    r.kind      = ROW_ITEM;
    r.idx       = REG_GAIN_P;
    r.value     = '0;
    r.err       = err[ERR_W-1:0];
    r.known     = 1'b1;
    r.drv.left  = GAIN_W'(l);
    r.drv.right = GAIN_W'(rr);
    r.drv.corr  = c[CORR_W-1:0];
    plan.push_back(r);
  endfunction

  function automatic void set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        gap_pct = 57;
        stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        gap_pct = 0;
        stall_pct = 57;
      end
      IDLE_BOTH: begin
        gap_pct = 18;
        stall_pct = 18;
      end
      default: begin
        gap_pct = 0;
        stall_pct = 0;
      end
    endcase
  endfunction

  task automatic reg_write(input reg_idx_t idx, input logic [GAIN_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GAIN_P:     cfg_gain_p = value;
      REG_GAIN_I:     cfg_gain_i = value;
      REG_GAIN_D:     cfg_gain_d = value;
      REG_BASE_SPEED: cfg_base_speed = value;
      default: ;
    endcase
  endtask

  // hold requests back until every expected result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_request(input logic [ERR_W-1:0] err, input bit known,
                              input drive_t drv);
    drive_t d;
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 60)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    steer_error <= err;
    do @(posedge clk); while (in_stall !== 1'b0);
    d = steer_update(err);
    expected_drives.push_back(known ? drv : d);
  endtask

  // receiver: random stall, compare each taken result with the oldest expectation
  always @(posedge clk) begin
    drive_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen = results_seen + 1;
      if (expected_drives.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10)
          $display("result %0d arrived with none expected: left %0d right %0d corr %0d",
                   results_seen, left_drive, right_drive, steer_correction);
      end else begin
        want = expected_drives.pop_front();
        if (left_drive !== want.left || right_drive !== want.right ||
            steer_correction !== want.corr) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("result %0d: left exp %0d got %0d, right exp %0d got %0d, corr exp %0d got %0d",
                     results_seen, want.left, left_drive, want.right, right_drive,
                     want.corr, steer_correction);
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    drive_t none;
    int     drift;
    int     e;
    none = '0;

    // defaults after reset, errors at the range ends, zero divisor, saturation, integral clamp, lowered divisor
    plan_known(0, 85, 85, 0);
    plan_item(8);
    plan_item(-8);
    plan_item(15);
    plan_item(-16);
    plan_item(1);
    plan_write(REG_GAIN_I, 0);
    plan_write(REG_GAIN_P, 0);
    plan_write(REG_GAIN_D, 0);
    plan_write(REG_BASE_SPEED, 0);
    plan_known(5, 0, 0, 0);
    plan_write(REG_BASE_SPEED, 255);
    plan_known(-3, 255, 255, 0);
    plan_write(REG_GAIN_P, 255);
    plan_write(REG_GAIN_D, 255);
    plan_write(REG_BASE_SPEED, 128);
    plan_known(15, 255, 0, 8191);
    plan_known(-16, 0, 255, -8192);
    plan_known(15, 255, 0, 8191);
    plan_write(REG_GAIN_I, 2);
    plan_write(REG_GAIN_P, 1);
    plan_write(REG_GAIN_D, 0);
    plan_write(REG_BASE_SPEED, 85);
    for (int k = 0; k < 7; k++) plan_item(15);
    plan_write(REG_GAIN_I, 1);
    plan_item(-1);
    plan_item(-16);
    plan_item(0);
    plan_write(REG_GAIN_I, 255);
    plan_write(REG_GAIN_P, 8);
    plan_write(REG_GAIN_D, 255);
    plan_write(REG_BASE_SPEED, 0);
    plan_item(7);
    plan_item(-9);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    set_idle(IDLE_NONE);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        settle();
        reg_write(plan[i].idx, plan[i].value);
      end else begin
        send_request(plan[i].err, plan[i].known, plan[i].drv);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      reg_write(REG_GAIN_P, pick_setting(0));
      reg_write(REG_GAIN_I, pick_setting(1));
      reg_write(REG_GAIN_D, pick_setting(0));
      reg_write(REG_BASE_SPEED, pick_setting(0));
      set_idle(idle_mode_t'(ph % 4));
      drift = $urandom_range(0, 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 7) == 0)
          e = $urandom_range(0, 31);
        else if (drift == 1)
          e = $urandom_range(0, 8);
        else if (drift == 2)
          e = -int'($urandom_range(0, 8));
        else
          e = int'($urandom_range(0, 16)) - 8;
        send_request(e[ERR_W-1:0], 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    while (expected_drives.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
sv/pdsc_pkg.sv
sv/pdsc_regs.sv
sv/pdsc_seq.sv
sv/pdsc_dp.sv
sv/pid_differential_steering_core.sv
tb/sv/tb_pid_differential_steering_core.sv
